[rtl/core/sil_pkg.sv]
// Package for the sorted insertion list: key type, command codes and the
// control struct that the top level broadcasts to every storage cell.
// No dependencies; every other file of the block imports it.
package sil_pkg;

    // Signed key as stored and compared in the cells.
    typedef logic signed [31:0] key_t;

    // Command codes carried on the request channel.
    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed
    {
        logic insert;   // place new_key into the chain this cycle
        logic rotate;   // move every occupied key one place toward the head
        key_t new_key;  // key being inserted
    } sil_ctl_t;

endpackage

[rtl/core/sil_in_if.sv]
// Request channel of the sorted insertion list: valid/ready with command and key.
// Depends on sil_pkg for the key and command types.
interface sil_in_if;
    logic          valid;
    logic          ready;
    sil_pkg::cmd_t command;
    sil_pkg::key_t key_in;

    modport source (output valid, output command, output key_in, input ready);
    modport sink   (input valid, input command, input key_in, output ready);
endinterface

[rtl/core/sil_out_if.sv]
// Result channel of the sorted insertion list: valid/ready with key and flags.
// Depends on sil_pkg for the key type.
interface sil_out_if;
    logic          valid;
    logic          ready;
    sil_pkg::key_t key_out;
    logic          entry_valid;
    logic          last;
    logic          overflowed;

    modport source (output valid, output key_out, output entry_valid,
                    output last, output overflowed, input ready);
    modport sink   (input valid, input key_out, input entry_valid,
                    input last, input overflowed, output ready);
endinterface

[rtl/core/sil_cell.sv]
// One storage cell of the sorted chain: holds a key, compares it with an
// incoming key and takes its own, a neighbor's, the head's or the new key.
// Depends on sil_pkg for key_t and sil_ctl_t.
module sil_cell
(
    input  logic              clk,
    input  sil_pkg::sil_ctl_t ctl,
    input  logic              occ,        // this cell holds a stored key
    input  logic              prev_keep,  // lower neighbor keeps its key
    input  sil_pkg::key_t     prev_key,   // key of the lower neighbor
    input  logic              next_occ,   // upper neighbor holds a stored key
    input  sil_pkg::key_t     next_key,   // key of the upper neighbor
    input  sil_pkg::key_t     head_key,   // key of the head cell
    output sil_pkg::key_t     key,
    output logic              keep        // this key stays in place on insert
);
    import sil_pkg::*;

    key_t key_reg;
    key_t key_next;

    // A stored key smaller than the new one stays put; the first cell that
    // does not keep takes the new key and the cells above it shift up.
    assign keep = occ && (key_reg < ctl.new_key);

    always_comb
    begin
        key_next = key_reg;
        if (ctl.insert)
        begin
            if (!keep)
            begin
                key_next = prev_keep ? ctl.new_key : prev_key;
            end
        end
        else if (ctl.rotate)
        begin
            // The last occupied cell wraps the head key around.
            key_next = next_occ ? next_key : head_key;
        end
    end

    // Key storage needs no reset; occupancy comes from the entry count.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

[rtl/core/sorted_insertion_list.sv]
// Top level of the sorted insertion list: a chain of compare-and-shift cells
// with the entry count, the overflow flag and the read-out sequencer.
// Depends on sil_pkg, sil_in_if, sil_out_if and sil_cell.
//
//  channel   dir  payload                                       beat when
//  request   in   command, key_in                               valid && ready
//  result    out  key_out, entry_valid, last, overflowed        valid && ready
//
// On an insert every cell compares in parallel and the chain shifts, so
// inserts are accepted back to back. An accepted read streams one key per
// cycle, unless the result is stalled, from the head cell while the ring
// of occupied cells rotates; n keys take n beats (one beat if empty), and the
// request side waits until the last beat is taken. A stalled result holds, as
// the ring only turns on a result beat. Reset clears the count and the flag.
module sorted_insertion_list
#(
    parameter int DEPTH = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    sil_in_if.sink    request,
    sil_out_if.source result
);
    import sil_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          overflow_reg, overflow_next;

    sil_ctl_t ctl;
    key_t     cell_key  [DEPTH];
    logic     cell_occ  [DEPTH];
    logic     keep_chain[DEPTH+1];

    logic in_beat;
    logic out_beat;
    logic full;
    logic is_last;

    assign in_beat  = request.valid && request.ready;
    assign out_beat = result.valid && result.ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign is_last  = (remain_reg == '0) || (remain_reg == CW'(1));

    // Control broadcast to the chain.
    always_comb
    begin
        ctl.insert  = in_beat && (request.command == CMD_INSERT) && !full;
        ctl.rotate  = out_beat && (count_reg != '0);
        ctl.new_key = request.key_in;
    end

    // Cell chain; cell 0 sees a keeping neighbor so it can take the new key.
    assign keep_chain[0] = 1'b1;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic next_occ;
        key_t next_key;

        assign cell_occ[i] = (count_reg > CW'(i));

        if (i == DEPTH - 1)
        begin : g_top
            assign next_occ = 1'b0;
            assign next_key = cell_key[0];
        end
        else
        begin : g_mid
            assign next_occ = (count_reg > CW'(i + 1));
            assign next_key = cell_key[i + 1];
        end

        sil_cell u_cell
        (
            .clk       (clk),
            .ctl       (ctl),
            .occ       (cell_occ[i]),
            .prev_keep (keep_chain[i]),
            .prev_key  ((i == 0) ? request.key_in : cell_key[(i == 0) ? 0 : i - 1]),
            .next_occ  (next_occ),
            .next_key  (next_key),
            .head_key  (cell_key[0]),
            .key       (cell_key[i]),
            .keep      (keep_chain[i + 1])
        );
    end

    // Sequencer, entry count and sticky overflow flag.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (request.command == CMD_READ)
                    begin
                        state_next  = ST_READ;
                        remain_next = count_reg;
                    end
                    else if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_READ:
            begin
                if (out_beat)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            remain_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            overflow_reg <= overflow_next;
        end
    end

    // Handshake and result payload, taken straight from the head cell.
    assign request.ready      = (state_reg == ST_IDLE);
    assign result.valid       = (state_reg == ST_READ);
    assign result.entry_valid = (count_reg != '0);
    assign result.key_out     = (count_reg != '0) ? cell_key[0] : key_t'(0);
    assign result.last        = is_last;
    assign result.overflowed  = overflow_reg;

endmodule
